// ===== src/pcs_pkg.sv =====
package pcs_pkg;

  localparam int NUM_CHANNELS      = 6;
  localparam int ORDER_DEPTH       = 64;
  localparam int STEPS_PER_PATTERN = 16;
  localparam int RAM_DEPTH         = NUM_CHANNELS * ORDER_DEPTH;
  localparam int ADDR_W            = 9;
  localparam int CH_W              = 3;
  localparam int IDX_W             = 6;
  localparam int POS_W             = 7;
  localparam int STEP_W            = 8;
  localparam int PAT_W             = 8;
  localparam int BPB_W             = 5;
  localparam int TICK_W            = 7;
  localparam logic [BPB_W-1:0] BPB_RESET = 5'd4;
  localparam logic [BPB_W-1:0] BPB_MAX   = 5'd16;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_PLAY    = 3'd2,
    OP_STOP    = 3'd3,
    OP_RESTART = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH,
    ST_A_RD, ST_A_EV, ST_A_RD2, ST_A_EV2,
    ST_RW, ST_R0_EV, ST_RW_RD, ST_RW_EV, ST_A_NEXT,
    ST_EMIT_CHK, ST_E_RD, ST_E_WAIT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic clr_wr;
    logic ord_wr;
    logic play;
    logic restart;
    logic stop_emit;
    logic tick_disarm;
    logic tick_eval;
    logic rd;
    logic step_inc;
    logic set_sync;
    logic set_inactive;
    logic rw_dec;
    logic rw_found;
    logic next_chan;
    logic emit_load;
    logic tick_done;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic clr_done;
    logic running;
    logic primed;
    logic bar;
    logic emit_now;
    logic ram_zero;
    logic step_wrap;
    logic pos_zero;
    logic last_chan;
    logic out_full;
  } status_t;

  // A tick starts a bar when its count is a multiple of four times the beats per bar.
  function automatic logic bar_start(input logic [TICK_W-1:0] t, input logic [BPB_W-1:0] bpb);
    logic hit;
    logic [9:0] prod;
    hit = 1'b0;
    for (int k = 0; k < 32; k++) begin
      prod = 10'(k) * 10'(bpb);
      if (prod == 10'(t[TICK_W-1:2])) hit = 1'b1;
    end
    return hit && (t[1:0] == 2'd0);
  endfunction

endpackage

// ===== src/pcs_ram.sv =====
module pcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== src/pcs_datapath.sv =====
module pcs_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  pcs_pkg::cmd_t           cmd,
  output pcs_pkg::status_t        sts,
  input  logic                    cfg_wr_en,
  input  logic [4:0]              cfg_wr_data,
  input  logic [23:0]             s_tdata,
  input  logic [2:0]              s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [23:0]             m_tdata,
  output logic                    m_tlast
);
  import pcs_pkg::*;

  logic [BPB_W-1:0]  bpb;
  logic [BPB_W-1:0]  bpb_eff;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] t_eff;
  logic              running, primed, bar;
  logic [STEP_W-1:0] step [NUM_CHANNELS];
  logic [POS_W-1:0]  pos [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] active, sync;
  logic [CH_W-1:0]   cur;
  logic [ADDR_W-1:0] clr_addr;
  logic [2:0]        in_op;
  logic [CH_W-1:0]   in_ch;
  logic [IDX_W-1:0]  in_idx;
  logic [PAT_W-1:0]  in_val;
  logic              in_fs;
  logic              oob;
  logic [PAT_W-1:0]  ram_q;
  logic [PAT_W-1:0]  pattern;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PAT_W-1:0]  wdata;
  logic [STEP_W-1:0] step_plus;
  logic              last_c;

  assign bpb_eff   = (bpb == '0) ? BPB_W'(1) : ((bpb > BPB_MAX) ? BPB_MAX : bpb);
  assign t_eff     = bar ? '0 : tick_count;
  assign step_plus = step[cur] + STEP_W'(1);
  assign last_c    = (cur == CH_W'(NUM_CHANNELS - 1));
  assign pattern   = oob ? '0 : ram_q;

  assign we    = cmd.clr_wr || (cmd.ord_wr && (in_ch < CH_W'(NUM_CHANNELS)));
  assign waddr = cmd.clr_wr ? clr_addr : {in_ch, in_idx};
  assign wdata = cmd.clr_wr ? '0 : in_val;
  assign raddr = {cur, pos[cur][IDX_W-1:0]};

  pcs_ram #(.WIDTH(PAT_W), .DEPTH(RAM_DEPTH), .AW(ADDR_W)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(cmd.rd), .raddr(raddr), .rdata(ram_q)
  );

  always_comb begin
    sts.op        = op_t'(in_op);
    sts.clr_done  = (clr_addr == ADDR_W'(RAM_DEPTH - 1));
    sts.running   = running;
    sts.primed    = primed;
    sts.bar       = bar;
    sts.emit_now  = (t_eff[1:0] == 2'd0);
    sts.ram_zero  = oob || (ram_q == '0);
    sts.step_wrap = (step_plus == STEP_W'(STEPS_PER_PATTERN));
    sts.pos_zero  = (pos[cur] == '0);
    sts.last_chan = last_c;
    sts.out_full  = m_tvalid;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_op  <= s_tuser;
      in_ch  <= s_tdata[2:0];
      in_idx <= s_tdata[8:3];
      in_val <= s_tdata[16:9];
      in_fs  <= s_tdata[17];
    end
    if (cmd.rd) oob <= pos[cur][POS_W-1];
    if (cmd.tick_eval) bar <= bar_start(tick_count, bpb_eff);
    if (cmd.stop_emit) begin
      m_tdata <= {running, 23'd0};
      m_tlast <= 1'b1;
    end else if (cmd.emit_load) begin
      m_tdata <= {1'b0, active[cur], bar & sync[cur], pattern, pos[cur][IDX_W-1:0],
                  step[cur][3:0], cur};
      m_tlast <= last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bpb        <= BPB_RESET;
      tick_count <= '0;
      running    <= 1'b0;
      primed     <= 1'b0;
      active     <= '0;
      sync       <= '0;
      cur        <= '0;
      clr_addr   <= '0;
      m_tvalid   <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        step[c] <= '0;
        pos[c]  <= '0;
      end
    end else begin
      if (cfg_wr_en) bpb <= cfg_wr_data;
      if (cmd.clr_wr) clr_addr <= clr_addr + ADDR_W'(1);
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cmd.stop_emit || cmd.emit_load) m_tvalid <= 1'b1;
      if (cmd.stop_emit) running <= 1'b0;
      if (cmd.play && !running) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (in_fs) begin
            step[c] <= '0;
            pos[c]  <= '0;
          end else begin
            step[c] <= '1;
          end
        end
        tick_count <= '0;
        primed     <= 1'b1;
        running    <= 1'b1;
      end
      if (cmd.restart || cmd.tick_disarm) begin
        tick_count <= '0;
        primed     <= 1'b0;
      end
      if (cmd.tick_eval) begin
        sync <= '0;
        cur  <= '0;
      end
      if (cmd.step_inc) begin
        active[cur] <= 1'b1;
        if (step_plus == STEP_W'(STEPS_PER_PATTERN)) begin
          step[cur] <= '0;
          if (pos[cur] < POS_W'(ORDER_DEPTH)) pos[cur] <= pos[cur] + POS_W'(1);
        end else begin
          step[cur] <= step_plus;
        end
      end
      if (cmd.set_sync) sync[cur] <= 1'b1;
      if (cmd.set_inactive) active[cur] <= 1'b0;
      if (cmd.rw_dec) pos[cur] <= pos[cur] - POS_W'(1);
      if (cmd.rw_found) begin
        pos[cur]  <= pos[cur] + POS_W'(1);
        sync[cur] <= 1'b1;
      end
      if (cmd.next_chan) cur <= last_c ? '0 : cur + CH_W'(1);
      if (cmd.tick_done) tick_count <= t_eff + TICK_W'(1);
    end
  end

endmodule

// ===== src/pcs_ctrl.sv =====
module pcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  pcs_pkg::status_t sts,
  output pcs_pkg::cmd_t    cmd
);
  import pcs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.op)
          OP_WRITE: begin
            cmd.ord_wr = 1'b1;
            state_next = ST_IDLE;
          end
          OP_PLAY: begin
            cmd.play   = 1'b1;
            state_next = ST_IDLE;
          end
          OP_STOP: begin
            if (!sts.out_full) begin
              cmd.stop_emit = 1'b1;
              state_next    = ST_IDLE;
            end
          end
          OP_RESTART: begin
            cmd.restart = 1'b1;
            state_next  = ST_IDLE;
          end
          OP_TICK: begin
            if (!sts.running) begin
              state_next = ST_IDLE;
            end else if (sts.primed) begin
              cmd.tick_disarm = 1'b1;
              state_next      = ST_IDLE;
            end else begin
              cmd.tick_eval = 1'b1;
              state_next    = ST_EMIT_CHK;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_EMIT_CHK: begin
        // The bar flag is known here; a bar walks every channel first.
        if (sts.bar)
          state_next = ST_A_RD;
        else if (sts.emit_now)
          state_next = ST_E_RD;
        else begin
          cmd.tick_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_A_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_A_EV;
      end
      ST_A_EV: begin
        if (sts.ram_zero) begin
          state_next = ST_RW;
        end else begin
          cmd.step_inc = 1'b1;
          if (sts.step_wrap) begin
            state_next = ST_A_RD2;
          end else begin
            cmd.set_sync = 1'b1;
            state_next   = ST_A_NEXT;
          end
        end
      end
      ST_A_RD2: begin
        cmd.rd     = 1'b1;
        state_next = ST_A_EV2;
      end
      ST_A_EV2: begin
        if (sts.ram_zero) begin
          state_next = ST_RW;
        end else begin
          cmd.set_sync = 1'b1;
          state_next   = ST_A_NEXT;
        end
      end
      ST_RW: begin
        if (sts.pos_zero) begin
          cmd.rd     = 1'b1;
          state_next = ST_R0_EV;
        end else begin
          cmd.rw_dec = 1'b1;
          state_next = ST_RW_RD;
        end
      end
      ST_R0_EV: begin
        if (sts.ram_zero) cmd.set_inactive = 1'b1;
        else cmd.set_sync = 1'b1;
        state_next = ST_A_NEXT;
      end
      ST_RW_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_RW_EV;
      end
      ST_RW_EV: begin
        if (sts.ram_zero) begin
          cmd.rw_found = 1'b1;
          state_next   = ST_A_NEXT;
        end else begin
          state_next = ST_RW;
        end
      end
      ST_A_NEXT: begin
        cmd.next_chan = 1'b1;
        state_next    = sts.last_chan ? ST_E_RD : ST_A_RD;
      end
      ST_E_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (!sts.out_full) begin
          cmd.emit_load = 1'b1;
          cmd.next_chan = 1'b1;
          if (sts.last_chan) begin
            cmd.tick_done = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_E_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/pattern_chain_step_sequencer_unit.sv =====
// Pattern chain step sequencer for six tracker channels.
// Input words arrive on s_tvalid/s_tready; s_tuser carries the operation code
// (tick, write order entry, play, stop, restart bar) and s_tdata its arguments.
// Result words leave on m_tvalid/m_tready with m_tlast on the final word of an item.
// A stop gives one word; a tick while playing (not the first after play) whose count
// is a multiple of four gives one status word per channel; all other items give no word.
// A bar start walks every channel through the single read port of the order memory,
// stepping back over order entries when a channel rewinds. One item is worked on
// at a time.
// After reset the order memory is cleared one entry a cycle, all 384 entries, while
// s_tready is low; beats_per_bar can be written at any time via cfg_wr_en.
// When the receiver stalls, the result word is held in the output register and
// the sequencer waits until it is taken before it loads the next word.
module pattern_chain_step_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,  // beats_per_bar
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,      // channel[2:0], index[8:3], value[16:9],
                                    // rewind_all[17], zero fill above
  input  logic [2:0]  s_tuser,      // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,      // chan_out[2:0], step_now[6:3], position_now[12:7],
                                    // pattern_now[20:13], synced[21], active[22],
                                    // prior_play[23]
  output logic        m_tlast
);
  import pcs_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // The controller sequences each item; the datapath holds all channel state.
  pcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .sts(sts), .cmd(cmd)
  );

  pcs_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule

// ===== src/pcs_checker.sv =====
module pcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // A held result word keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // The order memory is being cleared right after reset.
  a_clear: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("input taken or result shown during clearing");

  // A stop word that reports playing carries nothing else.
  a_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[23] |-> m_tdata[22:0] == 23'd0 && m_tlast)
    else $error("malformed stop word");

  // The status word of the last channel closes the item.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == 3'd5 |-> m_tlast)
    else $error("last channel word without last mark");

endmodule

bind pattern_chain_step_sequencer_unit pcs_checker u_pcs_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
